// ===== hdl/endpoint_listener_manager_core_assert.svh =====
// ----------------------------------------------------------------------------
// Endpoint listener manager assertion macros
// Shorthand for clocked implication checks, sampled on clk with rst_n low
// disabling the check.
// ----------------------------------------------------------------------------
`ifndef ENDPOINT_LISTENER_MANAGER_CORE_ASSERT_SVH
`define ENDPOINT_LISTENER_MANAGER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ELM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ELM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/elm_pkg.sv =====
// ----------------------------------------------------------------------------
// Endpoint listener manager package
// Event kinds, action codes, listener states and sequencer states.
// ----------------------------------------------------------------------------
package elm_pkg;

    localparam int ENDPOINTS_DEF = 8;
    localparam int SLOTS_DEF     = 16;

    // Event kinds
    localparam logic [2:0] KIND_OPEN         = 3'd0;
    localparam logic [2:0] KIND_CLOSE        = 3'd1;
    localparam logic [2:0] KIND_SOCK_OPENED  = 3'd2;
    localparam logic [2:0] KIND_NEW_CONN     = 3'd3;
    localparam logic [2:0] KIND_FAILURE      = 3'd4;
    localparam logic [2:0] KIND_CHAN_CREATED = 3'd5;
    localparam logic [2:0] KIND_CHAN_GONE    = 3'd6;

    // Output actions
    localparam logic [2:0] ACT_SOCK_CLOSE    = 3'd0;
    localparam logic [2:0] ACT_CHAN_CLOSE    = 3'd1;
    localparam logic [2:0] ACT_CHAN_CREATE   = 3'd2;
    localparam logic [2:0] ACT_CREATE_SERVER = 3'd3;
    localparam logic [2:0] ACT_NOTIFY        = 3'd4;

    // Listener states
    localparam logic [1:0] LST_CLOSED  = 2'd0;
    localparam logic [1:0] LST_OPENING = 2'd1;
    localparam logic [1:0] LST_OPENED  = 2'd2;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_LOAD,
        SEQ_EXEC,
        SEQ_CLOSE_SCAN,
        SEQ_CLOSE_EMIT,
        SEQ_CLOSE_NOTIFY,
        SEQ_ADD_SCAN,
        SEQ_REMOVE_SCAN,
        SEQ_REMOVE_CHECK
    } seq_state_t;

endpackage

// ===== hdl/endpoint_listener_manager_core.sv =====
// Results leave through output registers loaded by the sequencer; busy stays high
// from acceptance until the sequencer is idle again. A close or failure of an opened
// configured endpoint, and a channel-created or channel-gone event on an opened
// endpoint, walk the slot table; the walk reads the slot memory through one registered
// read port, and no new transaction is accepted until it ends.
// Reset clears every endpoint's valid bit at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Endpoint listener manager core
// Tracks listener state and connection slots per endpoint and issues socket,
// channel and notify commands under a small sequencer.
// ----------------------------------------------------------------------------
`include "endpoint_listener_manager_core_assert.svh"

module endpoint_listener_manager_core
    import elm_pkg::*;
#(
    parameter int ENDPOINTS = ENDPOINTS_DEF,
    parameter int SLOTS     = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [7:0]  endpoint_index,
    input  logic        endpoint_configured,
    input  logic [15:0] aux_value,
    output logic        strobe,
    output logic [2:0]  action,
    output logic [15:0] target_index,
    output logic [7:0]  endpoint_out,
    output logic        close_status,
    output logic        last_of_run
);

    localparam int EP_AW    = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
    localparam int EP_DEPTH = 1 << EP_AW;
    localparam int SL_AW    = $clog2(SLOTS);
    localparam int SL_CW    = $clog2(SLOTS + 1);
    localparam int SM_DEPTH = EP_DEPTH << SL_AW;

    typedef struct packed {
        logic [1:0]       state;
        logic [15:0]      socket;
        logic [SL_AW-1:0] last;
        logic [SLOTS-1:0] used;
    } ep_rec_t;

    // Endpoint records and their valid bits; an invalid entry reads as closed.
    ep_rec_t              ep_mem [EP_DEPTH];
    logic [EP_DEPTH-1:0]  ep_vld_reg;
    ep_rec_t              ep_rdata_reg;
    logic                 vld_rd_reg;

    // Connection slot memory, meaningful only where the used bit is set.
    logic [15:0]          slot_mem [SM_DEPTH];
    logic [15:0]          slot_rdata_reg;

    seq_state_t           seq_reg, seq_next;

    logic [2:0]           kind_reg;
    logic [7:0]           ep_reg;
    logic                 cfg_reg;
    logic [15:0]          aux_reg;
    logic                 valid_reg;

    logic [1:0]           st_reg, st_next;
    logic [15:0]          sock_reg, sock_next;
    logic [SL_AW-1:0]     last_reg, last_next;
    logic [SLOTS-1:0]     used_reg, used_next;
    logic [SL_CW-1:0]     cnt_reg, cnt_next;
    logic [SL_AW-1:0]     pos_reg, pos_next;

    logic                 strobe_reg;
    logic [2:0]           action_reg;
    logic [15:0]          target_reg;
    logic [7:0]           ep_out_reg;
    logic                 status_reg;
    logic                 last_reg_out;

    logic                 accept;
    logic [EP_AW-1:0]     in_addr;
    logic [EP_AW-1:0]     ep_addr;
    logic [SL_AW-1:0]     cnt_idx;
    logic                 opened;
    logic                 status_w;
    logic                 rec_we;
    logic                 vld_clr;
    logic                 slot_we;
    logic                 emit;
    logic [2:0]           emit_action;
    logic [15:0]          emit_target;
    logic                 emit_status;
    logic                 emit_last;
    ep_rec_t              rec_wdata;

    assign busy     = (seq_reg != SEQ_IDLE);
    assign accept   = start && !busy;
    assign in_addr  = endpoint_index[EP_AW-1:0];
    assign ep_addr  = ep_reg[EP_AW-1:0];
    assign cnt_idx  = cnt_reg[SL_AW-1:0];
    assign opened   = valid_reg && (st_reg == LST_OPENED);
    assign status_w = (kind_reg == KIND_CLOSE) && cfg_reg && valid_reg;

    assign rec_wdata.state  = st_next;
    assign rec_wdata.socket = sock_next;
    assign rec_wdata.last   = last_next;
    assign rec_wdata.used   = used_next;

    always_comb
    begin
        seq_next    = seq_reg;
        st_next     = st_reg;
        sock_next   = sock_reg;
        last_next   = last_reg;
        used_next   = used_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        rec_we      = 1'b0;
        vld_clr     = 1'b0;
        slot_we     = 1'b0;
        emit        = 1'b0;
        emit_action = ACT_NOTIFY;
        emit_target = 16'(ep_reg);
        emit_status = 1'b0;
        emit_last   = 1'b0;

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    seq_next = SEQ_LOAD;
                end
            end

            SEQ_LOAD:
            begin
                if (vld_rd_reg)
                begin
                    st_next   = ep_rdata_reg.state;
                    sock_next = ep_rdata_reg.socket;
                    last_next = ep_rdata_reg.last;
                    used_next = ep_rdata_reg.used;
                end
                else
                begin
                    st_next   = LST_CLOSED;
                    sock_next = '0;
                    last_next = '0;
                    used_next = '0;
                end
                seq_next = SEQ_EXEC;
            end

            SEQ_EXEC:
            begin
                seq_next = SEQ_IDLE;
                case (kind_reg)
                    KIND_OPEN:
                    begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        if (cfg_reg && valid_reg && (st_reg == LST_CLOSED))
                        begin
                            st_next     = LST_OPENING;
                            rec_we      = 1'b1;
                            emit_action = ACT_CREATE_SERVER;
                        end
                    end

                    KIND_CLOSE, KIND_FAILURE:
                    begin
                        if (cfg_reg && opened)
                        begin
                            cnt_next = '0;
                            seq_next = SEQ_CLOSE_SCAN;
                        end
                        else
                        begin
                            if (cfg_reg && valid_reg && (st_reg == LST_OPENING))
                            begin
                                vld_clr = 1'b1;
                            end
                            emit        = 1'b1;
                            emit_status = status_w;
                            emit_last   = 1'b1;
                        end
                    end

                    KIND_SOCK_OPENED:
                    begin
                        if (valid_reg && (st_reg == LST_OPENING))
                        begin
                            st_next   = LST_OPENED;
                            sock_next = aux_reg;
                            rec_we    = 1'b1;
                        end
                        else
                        begin
                            emit        = 1'b1;
                            emit_action = ACT_SOCK_CLOSE;
                            emit_target = aux_reg;
                            emit_last   = 1'b1;
                        end
                    end

                    KIND_NEW_CONN:
                    begin
                        emit        = 1'b1;
                        emit_action = opened ? ACT_CHAN_CREATE : ACT_SOCK_CLOSE;
                        emit_target = aux_reg;
                        emit_last   = 1'b1;
                    end

                    KIND_CHAN_CREATED:
                    begin
                        if (opened)
                        begin
                            cnt_next = '0;
                            if (last_reg == SL_AW'(SLOTS - 1))
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                pos_next = last_reg + 1'b1;
                            end
                            seq_next = SEQ_ADD_SCAN;
                        end
                        else
                        begin
                            emit        = 1'b1;
                            emit_action = ACT_CHAN_CLOSE;
                            emit_target = aux_reg;
                            emit_last   = 1'b1;
                        end
                    end

                    KIND_CHAN_GONE:
                    begin
                        if (opened)
                        begin
                            cnt_next = '0;
                            seq_next = SEQ_REMOVE_SCAN;
                        end
                    end

                    default:
                    begin
                        seq_next = SEQ_IDLE;
                    end
                endcase
            end

            SEQ_CLOSE_SCAN:
            begin
                if (cnt_reg == SL_CW'(SLOTS))
                begin
                    emit        = 1'b1;
                    emit_action = ACT_SOCK_CLOSE;
                    emit_target = sock_reg;
                    seq_next    = SEQ_CLOSE_NOTIFY;
                end
                else if (used_reg[cnt_idx])
                begin
                    // The slot read issued this cycle is consumed next cycle.
                    seq_next = SEQ_CLOSE_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            SEQ_CLOSE_EMIT:
            begin
                emit        = 1'b1;
                emit_action = ACT_CHAN_CLOSE;
                emit_target = slot_rdata_reg;
                cnt_next    = cnt_reg + 1'b1;
                seq_next    = SEQ_CLOSE_SCAN;
            end

            SEQ_CLOSE_NOTIFY:
            begin
                vld_clr     = 1'b1;
                emit        = 1'b1;
                emit_status = status_w;
                emit_last   = 1'b1;
                seq_next    = SEQ_IDLE;
            end

            SEQ_ADD_SCAN:
            begin
                if (cnt_reg == SL_CW'(SLOTS))
                begin
                    emit        = 1'b1;
                    emit_action = ACT_CHAN_CLOSE;
                    emit_target = aux_reg;
                    emit_last   = 1'b1;
                    seq_next    = SEQ_IDLE;
                end
                else if (!used_reg[pos_reg])
                begin
                    used_next[pos_reg] = 1'b1;
                    last_next          = pos_reg;
                    rec_we             = 1'b1;
                    slot_we            = 1'b1;
                    seq_next           = SEQ_IDLE;
                end
                else
                begin
                    if (pos_reg == SL_AW'(SLOTS - 1))
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            SEQ_REMOVE_SCAN:
            begin
                if (cnt_reg == SL_CW'(SLOTS))
                begin
                    seq_next = SEQ_IDLE;
                end
                else if (used_reg[cnt_idx])
                begin
                    seq_next = SEQ_REMOVE_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            SEQ_REMOVE_CHECK:
            begin
                if (slot_rdata_reg == aux_reg)
                begin
                    used_next[cnt_idx] = 1'b0;
                    rec_we             = 1'b1;
                    seq_next           = SEQ_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    seq_next = SEQ_REMOVE_SCAN;
                end
            end

            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= SEQ_IDLE;
            strobe_reg <= 1'b0;
            ep_vld_reg <= '0;
        end
        else
        begin
            seq_reg    <= seq_next;
            strobe_reg <= emit;
            if (rec_we)
            begin
                ep_vld_reg[ep_addr] <= 1'b1;
            end
            else if (vld_clr)
            begin
                ep_vld_reg[ep_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind;
            ep_reg       <= endpoint_index;
            cfg_reg      <= endpoint_configured;
            aux_reg      <= aux_value;
            valid_reg    <= ({1'b0, endpoint_index} < 9'(ENDPOINTS));
            ep_rdata_reg <= ep_mem[in_addr];
            vld_rd_reg   <= ep_vld_reg[in_addr];
        end
        if (rec_we)
        begin
            ep_mem[ep_addr] <= rec_wdata;
        end
        if (slot_we)
        begin
            slot_mem[{ep_addr, pos_reg}] <= aux_reg;
        end
        slot_rdata_reg <= slot_mem[{ep_addr, cnt_idx}];

        st_reg   <= st_next;
        sock_reg <= sock_next;
        last_reg <= last_next;
        used_reg <= used_next;
        cnt_reg  <= cnt_next;
        pos_reg  <= pos_next;

        if (emit)
        begin
            action_reg   <= emit_action;
            target_reg   <= emit_target;
            ep_out_reg   <= ep_reg;
            status_reg   <= emit_status;
            last_reg_out <= emit_last;
        end
    end

    assign strobe       = strobe_reg;
    assign action       = action_reg;
    assign target_index = target_reg;
    assign endpoint_out = ep_out_reg;
    assign close_status = status_reg;
    assign last_of_run  = last_reg_out;

    `ELM_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "accepted transaction did not raise busy")
    `ELM_ASSERT_IMP(a_more_keeps_busy, strobe && !last_of_run, busy, "results pending but sequencer idle")
    `ELM_ASSERT_IMP(a_status_on_notify, strobe && close_status, (action == ACT_NOTIFY) && last_of_run, "close status on a non-notify result")
    `ELM_ASSERT_IMP(a_result_from_work, strobe, $past(busy), "result produced while idle")
    `ELM_ASSERT_IMP(a_scan_bound, (seq_reg == SEQ_CLOSE_SCAN) || (seq_reg == SEQ_ADD_SCAN) || (seq_reg == SEQ_REMOVE_SCAN), cnt_reg <= SL_CW'(SLOTS), "slot counter ran past the table")

endmodule

// ===== verif/endpoint_listener_manager_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endpoint listener manager core testbench
// Drives open, close, socket, connection and channel transactions through the
// start/busy handshake. A cycle-free predictor of the listener table works out
// the command stream that each transaction should cause, and a monitor checks
// every strobed command against it field by field.
// ----------------------------------------------------------------------------
module endpoint_listener_manager_core_test;
    import elm_pkg::*;

    localparam int ENDPOINTS = ENDPOINTS_DEF;
    localparam int SLOTS     = SLOTS_DEF;
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int RANDOM_EVENTS = 80;
    localparam int MAX_REPORTS   = 60;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  ep;
        logic        cfg;
        logic [15:0] aux;
    } listener_event_t;

    typedef struct {
        logic [2:0]  act;
        logic [15:0] target;
        logic [7:0]  ep;
        logic        status;
        logic        last;
    } listener_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  kind = 3'd0;
    logic [7:0]  endpoint_index = 8'd0;
    logic        endpoint_configured = 1'b0;
    logic [15:0] aux_value = 16'd0;
    logic        strobe;
    logic [2:0]  action;
    logic [15:0] target_index;
    logic [7:0]  endpoint_out;
    logic        close_status;
    logic        last_of_run;

    endpoint_listener_manager_core #(
        .ENDPOINTS (ENDPOINTS),
        .SLOTS     (SLOTS)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .kind                (kind),
        .endpoint_index      (endpoint_index),
        .endpoint_configured (endpoint_configured),
        .aux_value           (aux_value),
        .strobe              (strobe),
        .action              (action),
        .target_index        (target_index),
        .endpoint_out        (endpoint_out),
        .close_status        (close_status),
        .last_of_run         (last_of_run)
    );

    always #5 clk = ~clk;

    // Listener table as the block should hold it.
    logic [1:0]  ep_state   [ENDPOINTS];
    logic [15:0] ep_socket  [ENDPOINTS];
    logic        slot_taken [ENDPOINTS][SLOTS];
    logic [15:0] slot_conn  [ENDPOINTS][SLOTS];
    int          fill_ptr   [ENDPOINTS];

    listener_event_t pending_events[$];
    listener_cmd_t   expected_cmds[$];
    listener_cmd_t   step_cmds[$];

    listener_event_t in_flight;
    int  errors = 0;
    int  reports = 0;
    int  events_queued = 0;
    int  events_accepted = 0;
    int  cmds_checked = 0;
    int  table_full_rejects = 0;
    int  slot_closes = 0;
    int  gap_left = 0;
    bit  burst_mode = 1'b0;
    bit  taken;

    function automatic void push_cmd(logic [2:0] act, logic [15:0] tgt, logic [7:0] ep,
                                     logic st);
        listener_cmd_t c;
        c.act = act;
        c.target = tgt;
        c.ep = ep;
        c.status = st;
        c.last = 1'b0;
        step_cmds.push_back(c);
    endfunction

    function automatic void clear_listener(int e);
        ep_state[e] = LST_CLOSED;
        ep_socket[e] = 16'd0;
        fill_ptr[e] = 0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_taken[e][s] = 1'b0;
            slot_conn[e][s] = 16'd0;
        end
    endfunction

    // Tear-down of one endpoint: channels in slot order, then the listening socket.
    function automatic void shut_listener(int e);
        if (ep_state[e] == LST_OPENED) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_taken[e][s]) begin
                    push_cmd(ACT_CHAN_CLOSE, slot_conn[e][s], 8'(e), 1'b0);
                    slot_closes++;
                end
            end
            push_cmd(ACT_SOCK_CLOSE, ep_socket[e], 8'(e), 1'b0);
            clear_listener(e);
        end else if (ep_state[e] == LST_OPENING) begin
            clear_listener(e);
        end
    endfunction

    // The search starts one past the slot filled last and wraps around.
    function automatic bit place_channel(int e, logic [15:0] c);
        int s;
        s = fill_ptr[e];
        for (int k = 0; k < SLOTS; k++) begin
            s = (s + 1) % SLOTS;
            if (!slot_taken[e][s]) begin
                slot_taken[e][s] = 1'b1;
                slot_conn[e][s] = c;
                fill_ptr[e] = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void drop_channel(int e, logic [15:0] c);
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_taken[e][s] && slot_conn[e][s] == c) begin
                slot_taken[e][s] = 1'b0;
                slot_conn[e][s] = 16'd0;
                return;
            end
        end
    endfunction

    function automatic void apply_event(listener_event_t ev);
        bit valid;
        bit is_open;
        int e;
        valid = ev.ep < ENDPOINTS;
        e = valid ? int'(ev.ep) : 0;
        is_open = valid && ep_state[e] == LST_OPENED;
        step_cmds.delete();
        case (ev.kind)
            KIND_OPEN: begin
                if (ev.cfg && valid && ep_state[e] == LST_CLOSED) begin
                    ep_state[e] = LST_OPENING;
                    push_cmd(ACT_CREATE_SERVER, 16'(ev.ep), ev.ep, 1'b0);
                end else begin
                    push_cmd(ACT_NOTIFY, 16'(ev.ep), ev.ep, 1'b0);
                end
            end
            KIND_CLOSE, KIND_FAILURE: begin
                if (ev.cfg && valid)
                    shut_listener(e);
                push_cmd(ACT_NOTIFY, 16'(ev.ep), ev.ep,
                         (ev.kind == KIND_CLOSE) && ev.cfg && valid);
            end
            KIND_SOCK_OPENED: begin
                if (valid && ep_state[e] == LST_OPENING) begin
                    ep_state[e] = LST_OPENED;
                    ep_socket[e] = ev.aux;
                end else begin
                    push_cmd(ACT_SOCK_CLOSE, ev.aux, ev.ep, 1'b0);
                end
            end
            KIND_NEW_CONN: begin
                if (is_open)
                    push_cmd(ACT_CHAN_CREATE, ev.aux, ev.ep, 1'b0);
                else
                    push_cmd(ACT_SOCK_CLOSE, ev.aux, ev.ep, 1'b0);
            end
            KIND_CHAN_CREATED: begin
                if (!is_open) begin
                    push_cmd(ACT_CHAN_CLOSE, ev.aux, ev.ep, 1'b0);
                end else if (!place_channel(e, ev.aux)) begin
                    table_full_rejects++;
                    push_cmd(ACT_CHAN_CLOSE, ev.aux, ev.ep, 1'b0);
                end
            end
            KIND_CHAN_GONE: begin
                if (is_open)
                    drop_channel(e, ev.aux);
            end
            default: ;
        endcase
        if (step_cmds.size() != 0)
            step_cmds[step_cmds.size() - 1].last = 1'b1;
        foreach (step_cmds[i])
            expected_cmds.push_back(step_cmds[i]);
    endfunction

    function automatic void add_event(logic [2:0] k, logic [7:0] e, logic c, logic [15:0] a);
        listener_event_t ev;
        ev.kind = k;
        ev.ep = e;
        ev.cfg = c;
        ev.aux = a;
        pending_events.push_back(ev);
        if (k != KIND_UNUSED)
            events_queued++;
    endfunction

    // One listener lifetime with random traffic in between; now and then the
    // slot table is driven past full.
    function automatic void add_session();
        logic [15:0] pool[$];
        logic [15:0] c;
        logic [7:0]  e;
        int          n;
        bit          fill;
        e = 8'($urandom_range(0, ENDPOINTS - 1));
        fill = ($urandom_range(0, 7) == 0);
        n = fill ? $urandom_range(SLOTS + 1, SLOTS + 3) : $urandom_range(0, 7);
        add_event(KIND_OPEN, e, 1'b1, 16'($urandom));
        add_event(KIND_SOCK_OPENED, e, 1'($urandom), 16'($urandom));
        repeat (n) begin
            c = 16'($urandom);
            if (fill) begin
                add_event(KIND_CHAN_CREATED, e, 1'($urandom), c);
            end else begin
                case ($urandom_range(0, 3))
                    0: add_event(KIND_NEW_CONN, e, 1'($urandom), c);
                    1, 2: begin
                        // Reuse a known id now and then so duplicates sit in the table.
                        if (pool.size() != 0 && $urandom_range(0, 3) == 0)
                            c = pool[$urandom_range(0, pool.size() - 1)];
                        pool.push_back(c);
                        add_event(KIND_CHAN_CREATED, e, 1'($urandom), c);
                    end
                    default: begin
                        if (pool.size() != 0 && $urandom_range(0, 4) != 0)
                            c = pool[$urandom_range(0, pool.size() - 1)];
                        add_event(KIND_CHAN_GONE, e, 1'($urandom), c);
                    end
                endcase
            end
        end
        if ($urandom_range(0, 4) != 0)
            add_event($urandom_range(0, 2) == 0 ? KIND_FAILURE : KIND_CLOSE, e,
                      $urandom_range(0, 7) != 0, 16'($urandom));
    endfunction

    function automatic void add_noise();
        logic [7:0] e;
        e = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, ENDPOINTS + 1));
        add_event(3'($urandom_range(0, 7)), e, 1'($urandom), 16'($urandom));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: holds a transaction while busy, then idles or loads the next one.
    always @(posedge clk) begin
        if (rst_n) begin
            taken = start && (busy === 1'b0);
            if (taken) begin
                apply_event(in_flight);
                events_accepted++;
                if (events_accepted % 20 == 0)
                    burst_mode = ($urandom_range(0, 2) == 0);
            end
            if (!start || taken) begin
                if (gap_left > 0) begin
                    start <= 1'b0;
                    gap_left--;
                end else if (pending_events.size() != 0) begin
                    in_flight = pending_events.pop_front();
                    kind <= in_flight.kind;
                    endpoint_index <= in_flight.ep;
                    endpoint_configured <= in_flight.cfg;
                    aux_value <= in_flight.aux;
                    start <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            errors++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                         exp_v, act_v);
            reports++;
        end
    endtask

    // Monitor: every strobe is one command transaction, matched in order.
    always @(posedge clk) begin
        if (rst_n && strobe !== 1'b0) begin
            if (expected_cmds.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS)
                    $display("%0t: unexpected command, expected none, actual action %h target %h",
                             $time, action, target_index);
                reports++;
            end else begin
                listener_cmd_t want;
                want = expected_cmds.pop_front();
                compare_field("action", 16'(want.act), 16'(action));
                compare_field("target_index", want.target, target_index);
                compare_field("endpoint_out", 16'(want.ep), 16'(endpoint_out));
                compare_field("close_status", 16'(want.status), 16'(close_status));
                compare_field("last_of_run", 16'(want.last), 16'(last_of_run));
                cmds_checked++;
            end
        end
    end

    initial begin
        for (int e = 0; e < ENDPOINTS; e++)
            clear_listener(e);

        add_event(KIND_OPEN,         8'd0,   1'b0, 16'h0000);
        add_event(KIND_OPEN,         8'd255, 1'b1, 16'hFFFF);
        add_event(KIND_UNUSED,       8'd3,   1'b1, 16'h1111);
        add_event(KIND_CLOSE,        8'd0,   1'b1, 16'h0000);
        add_event(KIND_CLOSE,        8'd200, 1'b1, 16'h0000);
        add_event(KIND_SOCK_OPENED,  8'd0,   1'b1, 16'hFFFF);
        add_event(KIND_OPEN,         8'd0,   1'b1, 16'h0000);
        add_event(KIND_OPEN,         8'd0,   1'b1, 16'h0000);
        add_event(KIND_NEW_CONN,     8'd0,   1'b1, 16'h00AA);
        add_event(KIND_CHAN_CREATED, 8'd0,   1'b1, 16'h5555);
        add_event(KIND_SOCK_OPENED,  8'd0,   1'b0, 16'hFFFF);
        add_event(KIND_SOCK_OPENED,  8'd0,   1'b1, 16'h0001);
        add_event(KIND_NEW_CONN,     8'd0,   1'b1, 16'hFFFF);
        add_event(KIND_CHAN_CREATED, 8'd0,   1'b1, 16'h0000);
        add_event(KIND_CHAN_CREATED, 8'd0,   1'b1, 16'hFFFF);
        add_event(KIND_CHAN_GONE,    8'd0,   1'b1, 16'h0000);
        add_event(KIND_CHAN_GONE,    8'd0,   1'b1, 16'h1234);
        add_event(KIND_CHAN_CREATED, 8'd255, 1'b1, 16'h8000);
        add_event(KIND_CHAN_GONE,    8'd7,   1'b1, 16'h0000);
        add_event(KIND_CLOSE,        8'd0,   1'b0, 16'h0000);
        add_event(KIND_FAILURE,      8'd0,   1'b1, 16'h0000);
        add_event(KIND_OPEN,         8'd7,   1'b1, 16'h0000);
        add_event(KIND_CLOSE,        8'd7,   1'b1, 16'h0000);
        add_event(KIND_FAILURE,      8'd9,   1'b0, 16'h0000);
        add_event(KIND_NEW_CONN,     8'd8,   1'b1, 16'h7FFF);

        begin
            int target_count;
            target_count = events_queued + RANDOM_EVENTS;
            while (events_queued < target_count) begin
                if ($urandom_range(0, 9) < 7)
                    add_session();
                else
                    add_noise();
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_events.size() != 0 || start || expected_cmds.size() != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 10) @(posedge clk);

        $display("Ran %0d listener transactions and checked %0d commands.",
                 events_accepted, cmds_checked);
        $display("Close walks emitted %0d channel closes; %0d channels met a full slot table.",
                 slot_closes, table_full_rejects);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout waiting for the listener command stream to drain.");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
